### hw/rtl/fsir_pkg.sv
// shared types and constants for the first-seen index remap block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package fsir_pkg;

  // fixed field widths of the stream beats
  localparam int unsigned IDX_FIELD_W   = 16;
  localparam int unsigned NUM_BITS      = 16;
  localparam int unsigned COUNT_BITS    = 17;
  localparam int unsigned IN_TDATA_W    = 16;
  localparam int unsigned IN_TUSER_W    = 1;
  localparam int unsigned OUT_TDATA_W   = 40;
  localparam int unsigned OUT_TUSER_W   = 1;

  // parameter defaults
  localparam int unsigned INDEX_BITS_DEF  = 16;
  localparam int unsigned TABLE_DEPTH_DEF = 65536;

  // range compare width, holds the largest table depth
  localparam int unsigned CMP_W = 25;

  // mesh epoch tag kept with each table entry
  localparam int unsigned EPOCH_BITS = 8;
  localparam logic [EPOCH_BITS-1:0] EPOCH_MAX   = '1;
  localparam logic [EPOCH_BITS-1:0] EPOCH_SWEPT = '0;
  localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [EPOCH_BITS-1:0] tag;
    logic [NUM_BITS-1:0]   num;
  } entry_t;

  typedef enum logic [1:0] {
    SWEEP_IDLE = 2'b01,
    SWEEP_RUN  = 2'b10
  } sweep_state_t;

endpackage

`default_nettype wire

### hw/rtl/first_seen_index_remap.sv
// top level of the first-seen index remap block: stream ports, lookup pipeline
// depends on fsir_pkg, fsir_table and fsir_sweep
`timescale 1ns / 1ps
`default_nettype none

// first-seen index remap
//
// in_* channel: one old vertex index per beat, in_tuser flags the first beat of a mesh
// out_* channel: one beat per input beat with the compacted index, the first-seen
//   flag and the running count of distinct vertices in the mesh
// a result passes the lookup stage register and then the output register before it
//   shows on out_*; a receiver stall can hold it in either
// throughput: one beat per cycle when neither a clearing pass nor a receiver stall holds it; the table
//   is read at accept and written back from lookup; a same-entry write is forwarded to the next beat
// each table entry carries an epoch tag; a mesh start bumps the epoch, so old
//   marks go stale without touching the memory
// clearing pass: one walk over every table address after reset and again on every 255th mesh
//   start, when the epoch tag runs out; in_tready stays low meanwhile
// receiver stall: the lookup stage holds its beat behind a full output register,
//   and in_tready drops once both are occupied; nothing is dropped or repeated
// reset (rst_n low, synchronous): count zero, all marks clear, channels empty
module first_seen_index_remap #(
  parameter int unsigned INDEX_BITS  = fsir_pkg::INDEX_BITS_DEF,
  parameter int unsigned TABLE_DEPTH = fsir_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input beat
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [fsir_pkg::IN_TDATA_W-1:0]  in_tdata,   // [15:0] vertex_index
  input  wire logic [fsir_pkg::IN_TUSER_W-1:0]  in_tuser,   // [0] start_mesh
  // result beat
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [15:0] new_index, [32:16] distinct_count
  output logic [fsir_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic [fsir_pkg::OUT_TUSER_W-1:0]      out_tuser   // [0] first_seen
);

  import fsir_pkg::*;

  localparam int unsigned ADDR_BITS = $clog2(TABLE_DEPTH);
  localparam int unsigned IDX_W     = (INDEX_BITS < IDX_FIELD_W) ? INDEX_BITS : IDX_FIELD_W;
  localparam int unsigned PAD_W     = OUT_TDATA_W - NUM_BITS - COUNT_BITS;

  // input decode
  logic [CMP_W-1:0]     idx_ext;
  logic                 in_range;
  logic [ADDR_BITS-1:0] in_addr;
  logic                 in_fire;

  // memory ports
  logic                 wr_en;
  logic [ADDR_BITS-1:0] wr_addr;
  entry_t               wr_data;
  entry_t               rd_data;

  // clearing pass
  logic                 sweep_busy;
  logic [ADDR_BITS-1:0] sweep_addr;
  logic                 wrap_trig;

  // lookup stage
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_start_r;
  logic                 s1_range_r;
  logic [ADDR_BITS-1:0] s1_addr_r;
  logic                 fwd_hit_r;
  entry_t               fwd_data_r;
  logic                 s1_adv;

  // block state
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [EPOCH_BITS-1:0] epoch_r, epoch_nxt;

  // lookup results
  entry_t                entry;
  logic                  seen;
  logic                  fresh;
  logic [COUNT_BITS-1:0] cnt_base;
  logic [EPOCH_BITS-1:0] epoch_eff;
  logic [NUM_BITS-1:0]   number;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [NUM_BITS-1:0]   out_num_r;
  logic [COUNT_BITS-1:0] out_count_r;
  logic                  out_fresh_r;

  // index masked to INDEX_BITS, checked against the table depth
  assign idx_ext  = CMP_W'(in_tdata[IDX_W-1:0]);
  assign in_range = (idx_ext < CMP_W'(TABLE_DEPTH));
  assign in_addr  = idx_ext[ADDR_BITS-1:0];

  // a start beat on the last epoch waits in the lookup stage for a clearing pass
  assign wrap_trig = s1_valid_r && s1_start_r && (epoch_r == EPOCH_MAX) && !sweep_busy;
  assign s1_adv    = s1_valid_r && !sweep_busy && !wrap_trig && (!out_valid_r || out_tready);
  assign in_tready = !sweep_busy && (!s1_valid_r || s1_adv);
  assign in_fire   = in_tvalid && in_tready;

  // forwarded entry covers a write landing on the same edge as the read
  assign entry     = fwd_hit_r ? fwd_data_r : rd_data;
  assign epoch_eff = s1_start_r ? epoch_r + 1'b1 : epoch_r;
  assign cnt_base  = s1_start_r ? '0 : count_r;
  assign seen      = !s1_start_r && (entry.tag == epoch_r);
  assign fresh     = s1_range_r && !seen;

  always_comb begin
    if (fresh) begin
      number = cnt_base[NUM_BITS-1:0];
    end else if (s1_range_r) begin
      number = entry.num;
    end else begin
      number = '0;
    end
  end

  // counter saturates at its top
  assign count_nxt = (fresh && (cnt_base != COUNT_MAX)) ? cnt_base + 1'b1 : cnt_base;

  always_comb begin
    epoch_nxt = epoch_r;
    if (wrap_trig) begin
      epoch_nxt = EPOCH_SWEPT;
    end else if (s1_adv) begin
      epoch_nxt = epoch_eff;
    end
  end

  // write port: clearing pass, else write-back of a fresh entry
  always_comb begin
    if (sweep_busy) begin
      wr_en       = 1'b1;
      wr_addr     = sweep_addr;
      wr_data.tag = EPOCH_SWEPT;
      wr_data.num = '0;
    end else begin
      wr_en       = s1_adv && fresh;
      wr_addr     = s1_addr_r;
      wr_data.tag = epoch_eff;
      wr_data.num = cnt_base[NUM_BITS-1:0];
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      epoch_r     <= EPOCH_FIRST;
      fwd_hit_r   <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      epoch_r     <= epoch_nxt;
      if (s1_adv) begin
        count_r <= count_nxt;
      end
      if (in_fire) begin
        fwd_hit_r <= wr_en && (wr_addr == in_addr);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_start_r <= in_tuser[0];
      s1_range_r <= in_range;
      s1_addr_r  <= in_addr;
      fwd_data_r <= wr_data;
    end
    if (s1_adv) begin
      out_num_r   <= number;
      out_count_r <= count_nxt;
      out_fresh_r <= fresh;
    end
  end

  fsir_table #(
    .DEPTH     (TABLE_DEPTH),
    .ADDR_BITS (ADDR_BITS)
  ) u_table (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (in_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  fsir_sweep #(
    .DEPTH     (TABLE_DEPTH),
    .ADDR_BITS (ADDR_BITS)
  ) u_sweep (
    .clk   (clk),
    .rst_n (rst_n),
    .start (wrap_trig),
    .busy  (sweep_busy),
    .addr  (sweep_addr)
  );

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {PAD_W'(0), out_count_r, out_num_r};
  assign out_tuser[0] = out_fresh_r;

endmodule

`default_nettype wire

### hw/rtl/fsir_table.sv
// remap table memory: one write port, one registered read port
// depends on fsir_pkg for the entry type
`timescale 1ns / 1ps
`default_nettype none

module fsir_table #(
  parameter int unsigned DEPTH     = fsir_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned ADDR_BITS = $clog2(fsir_pkg::TABLE_DEPTH_DEF)
) (
  input  wire logic                 clk,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output fsir_pkg::entry_t          rd_data,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  fsir_pkg::entry_t          wr_data
);

  import fsir_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-before-write on a shared address
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### hw/rtl/fsir_sweep.sv
// clearing sequencer: walks every table address once after reset or on request
// depends on fsir_pkg for the state type
`timescale 1ns / 1ps
`default_nettype none

module fsir_sweep #(
  parameter int unsigned DEPTH     = fsir_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned ADDR_BITS = $clog2(fsir_pkg::TABLE_DEPTH_DEF)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  output logic [ADDR_BITS-1:0]      addr
);

  import fsir_pkg::*;

  localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(DEPTH - 1);

  sweep_state_t state_r, state_nxt;
  logic [ADDR_BITS-1:0] addr_r, addr_nxt;

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    unique case (state_r)
      SWEEP_IDLE: begin
        if (start) begin
          state_nxt = SWEEP_RUN;
          addr_nxt  = '0;
        end
      end
      SWEEP_RUN: begin
        addr_nxt = addr_r + 1'b1;
        if (addr_r == LAST_ADDR) begin
          state_nxt = SWEEP_IDLE;
          addr_nxt  = '0;
        end
      end
      default: begin
        state_nxt = SWEEP_IDLE;
        addr_nxt  = '0;
      end
    endcase
  end

  // reset starts a full pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SWEEP_RUN;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
    end
  end

  assign busy = (state_r == SWEEP_RUN);
  assign addr = addr_r;

endmodule

`default_nettype wire

### hw/rtl/fsir_checker.sv
// port-level checks for the first-seen index remap block, bound to the top level
// depends on fsir_pkg
`timescale 1ns / 1ps
`default_nettype none

module fsir_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [fsir_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [fsir_pkg::OUT_TUSER_W-1:0] out_tuser
);

  import fsir_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // a freshly numbered vertex is the last one counted
  a_fresh_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_tdata[15:0] == NUM_BITS'(out_tdata[32:16] - 17'd1))
    else $error("first-seen number does not match count");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:33] == 7'd0)
    else $error("padding bits set");

  // channels empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("block not empty after reset");

  // no beat taken at the start of the clearing pass after reset
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> ##1 !in_tready)
    else $error("input taken before table clear");

endmodule

bind first_seen_index_remap fsir_checker u_fsir_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

### test/first_seen_index_remap_tb.sv
// testbench for first_seen_index_remap: index stream driver, result monitor, predictor
// depends on fsir_pkg and the first_seen_index_remap rtl
`timescale 1ns / 1ps

module first_seen_index_remap_tb;
  import fsir_pkg::*;

  // longest quiet stretch allowed: room for the clearing pass after reset and at epoch wrap, with margin
  localparam int unsigned WATCHDOG_LIMIT = 3 * TABLE_DEPTH_DEF + 5000;
  localparam int unsigned PACE_SPAN      = 150;
  localparam int unsigned DRAIN_CYCLES   = 8;

  typedef enum int unsigned {
    PACE_FREE,
    PACE_SEND_IDLE,
    PACE_RECV_STALL,
    PACE_BOTH
  } pace_mode_t;

  typedef struct packed {
    logic [IDX_FIELD_W-1:0] vertex_index;
    logic                   start_mesh;
  } index_beat_t;

  typedef struct packed {
    logic [NUM_BITS-1:0]   new_index;
    logic                  first_seen;
    logic [COUNT_BITS-1:0] distinct_count;
  } remap_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  first_seen_index_remap u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: a mark is valid only when its mesh tag matches the current mesh
  int unsigned         mark_mesh [TABLE_DEPTH_DEF];
  logic [NUM_BITS-1:0] remap_num [TABLE_DEPTH_DEF];
  int unsigned         cur_mesh = 1;
  logic [COUNT_BITS-1:0] vertex_count = '0;

  index_beat_t   pending_beats [$];
  remap_result_t expected_remaps [$];
  index_beat_t   next_beat;
  remap_result_t want_remap;

  int unsigned beats_taken = 0;
  int unsigned mesh_starts = 0;
  int unsigned results_seen = 0;
  int unsigned fresh_results = 0;
  int unsigned peak_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  // compacted number of one old index; updates the marks and the running count
  function automatic remap_result_t remap_lookup(input logic [IDX_FIELD_W-1:0] old_index,
                                                 input logic start);
    remap_result_t          r;
    int unsigned            idx;
    logic [IDX_FIELD_W-1:0] slot;
    idx = 32'(old_index) & ((1 << INDEX_BITS_DEF) - 1);
    r = '0;
    if (start) begin
      cur_mesh++;
      vertex_count = '0;
    end
    if (idx < TABLE_DEPTH_DEF) begin
      slot = idx[IDX_FIELD_W-1:0];
      if (mark_mesh[slot] != cur_mesh) begin
        r.new_index = vertex_count[NUM_BITS-1:0];
        r.first_seen = 1'b1;
        remap_num[slot] = vertex_count[NUM_BITS-1:0];
        mark_mesh[slot] = cur_mesh;
        if (vertex_count != COUNT_MAX) vertex_count++;
      end else begin
        r.new_index = remap_num[slot];
      end
    end
    r.distinct_count = vertex_count;
    return r;
  endfunction

  function automatic pace_mode_t pace_mode();
    return pace_mode_t'((beats_taken / PACE_SPAN) % 4);
  endfunction

  function automatic int unsigned send_idle_pct();
    case (pace_mode())
      PACE_SEND_IDLE: return 48;
      PACE_BOTH:      return 12;
      default:        return 0;
    endcase
  endfunction

  function automatic int unsigned recv_stall_pct();
    case (pace_mode())
      PACE_RECV_STALL: return 48;
      PACE_BOTH:       return 12;
      default:         return 0;
    endcase
  endfunction

  // driver: predicts each beat as it is taken, then offers the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_remaps.push_back(remap_lookup(in_tdata[IDX_FIELD_W-1:0], in_tuser[0]));
        beats_taken++;
        if (in_tuser[0]) mesh_starts++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          next_beat = pending_beats.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= next_beat.vertex_index;
          in_tuser <= next_beat.start_mesh;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct());
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // monitor: each result beat against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_remaps.size() == 0) begin
        $error("result beat with no pending prediction: tdata %h tuser %h",
               out_tdata, out_tuser);
        mismatch_count++;
      end else begin
        want_remap = expected_remaps.pop_front();
        check_field("new_index", 32'(want_remap.new_index), 32'(out_tdata[15:0]));
        check_field("first_seen", 32'(want_remap.first_seen), 32'(out_tuser[0]));
        check_field("distinct_count", 32'(want_remap.distinct_count),
                    32'(out_tdata[32:16]));
        if (want_remap.first_seen) fresh_results++;
        if (32'(want_remap.distinct_count) > peak_count) begin
          peak_count = 32'(want_remap.distinct_count);
        end
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: %0d idle cycles, %0d predictions outstanding",
                 quiet_cycles, expected_remaps.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic add_beat(input logic [IDX_FIELD_W-1:0] idx, input logic start);
    index_beat_t b;
    b.vertex_index = idx;
    b.start_mesh = start;
    pending_beats.push_back(b);
  endtask

  // a mesh drawn from a pool of old indices, so repeats land at every distance
  task automatic add_mesh(input int unsigned len, input int unsigned pool_n,
                          input logic with_start);
    logic [IDX_FIELD_W-1:0] pool [$];
    for (int unsigned i = 0; i < pool_n; i++) begin
      pool.push_back(IDX_FIELD_W'($urandom_range(0, 65535)));
    end
    for (int unsigned i = 0; i < len; i++) begin
      add_beat(pool[$urandom_range(0, pool_n - 1)], with_start && (i == 0));
    end
  endtask

  task automatic add_random_mesh();
    int unsigned len;
    int unsigned pool_n;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
    pool_n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : $urandom_range(1, len);
    // now and then a mesh continues without a start flag
    add_mesh(len, pool_n, $urandom_range(0, 9) != 0);
  endtask

  initial begin
    // before any mesh start: extremes and one-apart repeats
    add_beat(16'h0000, 1'b0);
    add_beat(16'hFFFF, 1'b0);
    add_beat(16'h0000, 1'b0);
    add_beat(16'hFFFF, 1'b0);
    add_beat(16'h5555, 1'b0);
    add_beat(16'hAAAA, 1'b0);
    // start on an index marked in the previous mesh
    add_beat(16'h5555, 1'b1);
    add_beat(16'h5555, 1'b0);
    add_beat(16'h0000, 1'b0);
    add_beat(16'h5555, 1'b0);
    // back-to-back starts on the same index
    add_beat(16'hFFFF, 1'b1);
    add_beat(16'hFFFF, 1'b1);
    add_beat(16'hFFFF, 1'b0);
    add_beat(16'h0001, 1'b1);
    add_beat(16'h8000, 1'b0);
    add_beat(16'h0001, 1'b0);
    add_beat(16'hFFFE, 1'b0);
    add_beat(16'h7FFF, 1'b0);
    add_beat(16'h8000, 1'b0);
    add_beat(16'hAAAA, 1'b0);

    while (pending_beats.size() < 650) add_random_mesh();
    // many tiny meshes push the start count past an epoch wrap
    repeat (300) add_mesh($urandom_range(1, 3), $urandom_range(1, 2), 1'b1);
    add_mesh(400, 400, 1'b1);
    while (pending_beats.size() < 1720) add_random_mesh();
    // unstructured noise
    repeat (130) add_beat(IDX_FIELD_W'($urandom_range(0, 65535)), $urandom_range(0, 19) == 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_beats.size() != 0 || in_tvalid || expected_remaps.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d index beats across %0d mesh starts, all pacing modes",
             beats_taken, mesh_starts);
    $display("checked %0d results: %0d first seen, peak distinct count %0d",
             results_seen, fresh_results, peak_count);
    if (mismatch_count == 0 && expected_remaps.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
